// ----- rtl/fvsd_pkg.sv -----
package fvsd_pkg;

	// default sizes
	localparam int SENSOR_BITS_DEF = 12;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int SINE_DEPTH_DEF  = 256;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PPAIRS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VLIMIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;

	localparam logic [6:0]  RST_PPAIRS     = 7'd7;
	localparam logic [14:0] RST_SUPPLY     = 15'd12288;
	localparam logic [15:0] RST_PERIOD     = 16'd1000;

	// datapath widths
	localparam int VW = 52;   // phase voltages, Q41 volts
	localparam int NW = 55;   // duty numerator
	localparam int XW = 31;   // divider dividend
	localparam int QW = 16;   // duty quotient

	localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

	typedef struct packed {
		logic [6:0]  ppairs;
		logic        reverse;
		logic [15:0] offset;
		logic [14:0] vlimit;
		logic [14:0] supply;
		logic [15:0] period;
	} cfg_t;

	// data that rides alongside the divider
	typedef struct packed {
		logic [15:0]         angle;
		logic                sat;
		logic [2:0]          pinned;
		logic [2:0][QW-1:0]  pin_val;
	} side_t;

	// Q1.15 sine of a 32-bit turn fraction, Q30 taylor series on the folded quadrant
	function automatic logic signed [15:0] sine_from_frac(input logic [31:0] f);
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		quad = f[31:30];
		r = {34'd0, f[29:0]};
		if (quad[0]) begin
			r = 64'h4000_0000 - r;
		end
		x = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		q = (sum * 64'd32768 + 64'h2000_0000) >> 30;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return quad[1] ? -$signed(q[15:0]) : $signed(q[15:0]);
	endfunction

endpackage

// ----- rtl/foc_voltage_to_svpwm_duty.sv -----
// foc voltage modulator: rotor angle and dq voltage request in, three svpwm
// compare counts, electrical angle and a clamp flag out
//
// input channel: in_valid / in_ready with mech_angle, vq_cmd, vd_cmd
// output channel: out_valid / out_ready with duty_a/b/c, electrical_angle,
// saturated. one result request for every input request
// configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; 0 pole pairs, 1 reverse, 2 offset, 3 voltage limit, 4 supply, 5 period
//
// the path from input to output valid runs through 2 angle/table stages,
// 10 transform stages, 16 restoring divider stages (one duty bit each) and
// the output register. throughput is one request per clock while the receiver is not stalling
// all stages advance together; in_ready is high whenever the output register
// is empty or being taken, so a stalled receiver freezes every stage and
// nothing is dropped or duplicated
// reset clears every valid bit and loads the register defaults
// (7 pole pairs, forward, zero offset, zero limit, supply 12.0, period 1000)
module foc_voltage_to_svpwm_duty #(
	parameter int SENSOR_BITS      = fvsd_pkg::SENSOR_BITS_DEF,
	parameter int ANGLE_BITS       = fvsd_pkg::ANGLE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = fvsd_pkg::SINE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [SENSOR_BITS-1:0]           mech_angle,
	input  logic signed [15:0]               vq_cmd,
	input  logic signed [15:0]               vd_cmd,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      duty_a,
	output logic [15:0]                      duty_b,
	output logic [15:0]                      duty_c,
	output logic [15:0]                      electrical_angle,
	output logic                             saturated,
	input  logic                             cfg_we,
	input  logic [fvsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fvsd_pkg::CFG_W-1:0]       cfg_data
);
	import fvsd_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ppairs <= RST_PPAIRS;
			cfg_q.reverse <= 1'b0;
			cfg_q.offset <= '0;
			cfg_q.vlimit <= '0;
			cfg_q.supply <= RST_SUPPLY;
			cfg_q.period <= RST_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PPAIRS:     cfg_q.ppairs <= cfg_data[6:0];
				REG_REVERSE:    cfg_q.reverse <= cfg_data[0];
				REG_OFFSET:     cfg_q.offset <= cfg_data;
				REG_VLIMIT:     cfg_q.vlimit <= cfg_data[14:0];
				REG_SUPPLY:     cfg_q.supply <= cfg_data[14:0];
				REG_PERIOD:     cfg_q.period <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// one enable moves the whole pipeline
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// angle, clamp and sine/cosine lookup
	logic               v_t;
	logic [15:0]        ang_t;
	logic signed [15:0] vq_t, vd_t, sin_t, cos_t;
	logic               sat_t;

	fvsd_angle_trig #(
		.SENSOR_BITS      (SENSOR_BITS),
		.ANGLE_BITS       (ANGLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_in       (in_valid),
		.mech_angle (mech_angle),
		.vq_cmd     (vq_cmd),
		.vd_cmd     (vd_cmd),
		.cfg        (cfg_q),
		.v_out      (v_t),
		.ang_out    (ang_t),
		.vq_out     (vq_t),
		.vd_out     (vd_t),
		.sin_out    (sin_t),
		.cos_out    (cos_t),
		.sat_out    (sat_t)
	);

	// inverse park/clarke, min-max injection, duty numerator scaling
	logic               v_x;
	logic [2:0][XW-1:0] x_x;
	side_t              side_x;

	fvsd_transform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_t),
		.ang_in   (ang_t),
		.vq_in    (vq_t),
		.vd_in    (vd_t),
		.sin_in   (sin_t),
		.cos_in   (cos_t),
		.sat_in   (sat_t),
		.cfg      (cfg_q),
		.v_out    (v_x),
		.x_out    (x_x),
		.side_out (side_x)
	);

	// divide by the supply voltage
	logic               v_d;
	logic [2:0][QW-1:0] quo_d;
	side_t              side_d;

	fvsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_x),
		.x_in     (x_x),
		.supply   (cfg_q.supply),
		.side_in  (side_x),
		.v_out    (v_d),
		.quo_out  (quo_d),
		.side_out (side_d)
	);

	// output register: pinned duties bypass the quotient
	logic [2:0][QW-1:0] duty_n;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			duty_n[l] = side_d.pinned[l] ? side_d.pin_val[l] : quo_d[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			duty_a <= duty_n[0];
			duty_b <= duty_n[1];
			duty_c <= duty_n[2];
			electrical_angle <= side_d.angle;
			saturated <= side_d.sat;
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable({duty_a, duty_b, duty_c,
			electrical_angle, saturated}))
		else $error("result changed while stalled");

	a_out_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn before taken");
`endif

endmodule

// ----- rtl/fvsd_angle_trig.sv -----
module fvsd_angle_trig #(
	parameter int SENSOR_BITS      = fvsd_pkg::SENSOR_BITS_DEF,
	parameter int ANGLE_BITS       = fvsd_pkg::ANGLE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = fvsd_pkg::SINE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic [SENSOR_BITS-1:0]   mech_angle,
	input  logic signed [15:0]       vq_cmd,
	input  logic signed [15:0]       vd_cmd,
	input  fvsd_pkg::cfg_t           cfg,
	output logic                     v_out,
	output logic [15:0]              ang_out,
	output logic signed [15:0]       vq_out,
	output logic signed [15:0]       vd_out,
	output logic signed [15:0]       sin_out,
	output logic signed [15:0]       cos_out,
	output logic                     sat_out
);
	import fvsd_pkg::*;

	localparam int LD = $clog2(SINE_TABLE_DEPTH);
	localparam logic [LD-1:0] QTR = LD'(SINE_TABLE_DEPTH / 4);

	typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

	function automatic sine_tab_t build_sine();
		sine_tab_t   tab;
		logic [63:0] f;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			f = (64'(i) << 32) / SINE_TABLE_DEPTH;
			tab[i] = sine_from_frac(f[31:0]);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

	// stage 1: electrical angle and voltage clamp
	logic [SENSOR_BITS+ANGLE_BITS-1:0] mech_w;
	logic [16+ANGLE_BITS-1:0]          ofs_w;
	logic [ANGLE_BITS-1:0]             m_fwd;
	logic [ANGLE_BITS-1:0]             m_dir;
	logic [ANGLE_BITS+6:0]             m_prod;
	logic [ANGLE_BITS-1:0]             e_n;
	logic signed [16:0]                lim;
	logic signed [15:0]                vq_n;
	logic signed [15:0]                vd_n;
	logic                              sat_n;

	always_comb begin
		mech_w = {mech_angle, {ANGLE_BITS{1'b0}}};
		ofs_w = {cfg.offset, {ANGLE_BITS{1'b0}}};
		m_fwd = mech_w[SENSOR_BITS+ANGLE_BITS-1:SENSOR_BITS];
		m_dir = cfg.reverse ? (~m_fwd + 1'b1) : m_fwd;
		m_prod = m_dir * cfg.ppairs;
		e_n = m_prod[ANGLE_BITS-1:0] - ofs_w[16+ANGLE_BITS-1:16];
		lim = $signed({2'b00, cfg.vlimit});
		sat_n = 1'b0;
		vq_n = vq_cmd;
		vd_n = vd_cmd;
		if (17'(vq_cmd) > lim) begin
			vq_n = lim[15:0];
			sat_n = 1'b1;
		end else if (17'(vq_cmd) < -lim) begin
			vq_n = 16'(-lim);
			sat_n = 1'b1;
		end
		if (17'(vd_cmd) > lim) begin
			vd_n = lim[15:0];
			sat_n = 1'b1;
		end else if (17'(vd_cmd) < -lim) begin
			vd_n = 16'(-lim);
			sat_n = 1'b1;
		end
	end

	logic                    v_s1;
	logic [ANGLE_BITS-1:0]   e_s1;
	logic signed [15:0]      vq_s1;
	logic signed [15:0]      vd_s1;
	logic                    sat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= e_n;
			vq_s1 <= vq_n;
			vd_s1 <= vd_n;
			sat_s1 <= sat_n;
		end
	end

	// stage 2: table lookup
	logic [ANGLE_BITS+LD-1:0] idx_w;
	logic [16+ANGLE_BITS-1:0] ang_w;
	logic [LD-1:0]            idx_s;
	logic [LD-1:0]            idx_c;

	always_comb begin
		idx_w = {e_s1, {LD{1'b0}}};
		idx_s = idx_w[ANGLE_BITS+LD-1:ANGLE_BITS];
		idx_c = idx_s + QTR;
		ang_w = {e_s1, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_out <= SINE_TAB[idx_s];
			cos_out <= SINE_TAB[idx_c];
			ang_out <= ang_w[16+ANGLE_BITS-1:ANGLE_BITS];
			vq_out <= vq_s1;
			vd_out <= vd_s1;
			sat_out <= sat_s1;
		end
	end

endmodule

// ----- rtl/fvsd_transform.sv -----
module fvsd_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                v_in,
	input  logic [15:0]                         ang_in,
	input  logic signed [15:0]                  vq_in,
	input  logic signed [15:0]                  vd_in,
	input  logic signed [15:0]                  sin_in,
	input  logic signed [15:0]                  cos_in,
	input  logic                                sat_in,
	input  fvsd_pkg::cfg_t                      cfg,
	output logic                                v_out,
	output logic [2:0][fvsd_pkg::XW-1:0]        x_out,
	output fvsd_pkg::side_t                     side_out
);
	import fvsd_pkg::*;

	localparam int PIPE = 10;

	logic        v_s   [1:PIPE];
	logic [15:0] ang_s [1:7];
	logic        sat_s [1:7];

	logic [14:0] sup_eff;
	assign sup_eff = (cfg.supply == 15'd0) ? 15'd1 : cfg.supply;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= v_in;
			for (int k = 2; k <= PIPE; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end
	assign v_out = v_s[PIPE];

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s[1] <= ang_in;
			sat_s[1] <= sat_in;
			for (int k = 2; k <= 7; k++) begin
				ang_s[k] <= ang_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	// s1 products, s2 inverse park, s3 clarke product, s4 phases
	logic signed [31:0]   p_dc_s1, p_qs_s1, p_ds_s1, p_qc_s1;
	logic signed [32:0]   alpha_s2, beta_s2;
	logic signed [VW-1:0] va_s3, ah_s3;
	logic signed [49:0]   bk_s3;
	logic signed [VW-1:0] ph_s4 [3];
	logic signed [VW-1:0] ph_s5 [3];
	logic signed [VW-1:0] hi_s5, lo_s5;
	logic signed [VW:0]   sum_s6;
	logic signed [VW:0]   dbl_s6 [3];
	logic signed [NW-1:0] num_s7 [3];
	logic [46:0]          numlo_s8 [3];
	side_t                side_s8, side_s9, side_s10;
	logic [39:0]          plo_s9 [3];
	logic [38:0]          phi_s9 [3];

	logic signed [VW-1:0] hi_n, lo_n;
	logic signed [NW-1:0] sup_term;
	logic signed [NW-1:0] den;

	always_comb begin
		hi_n = ph_s4[0];
		lo_n = ph_s4[0];
		for (int l = 1; l < 3; l++) begin
			if (ph_s4[l] > hi_n) begin
				hi_n = ph_s4[l];
			end
			if (ph_s4[l] < lo_n) begin
				lo_n = ph_s4[l];
			end
		end
		sup_term = NW'($signed({1'b0, sup_eff, 31'd0}));
		den = NW'($signed({1'b0, sup_eff, 32'd0}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_dc_s1 <= vd_in * cos_in;
			p_qs_s1 <= vq_in * sin_in;
			p_ds_s1 <= vd_in * sin_in;
			p_qc_s1 <= vq_in * cos_in;

			alpha_s2 <= 33'(p_dc_s1) - 33'(p_qs_s1);
			beta_s2 <= 33'(p_ds_s1) + 33'(p_qc_s1);

			va_s3 <= VW'(alpha_s2) <<< 16;
			ah_s3 <= VW'(alpha_s2) <<< 15;
			bk_s3 <= beta_s2 * $signed({1'b0, SQRT3_HALF_Q16});

			ph_s4[0] <= va_s3;
			ph_s4[1] <= -ah_s3 + VW'(bk_s3);
			ph_s4[2] <= -ah_s3 - VW'(bk_s3);

			hi_s5 <= hi_n;
			lo_s5 <= lo_n;
			for (int l = 0; l < 3; l++) begin
				ph_s5[l] <= ph_s4[l];
			end

			sum_s6 <= (VW+1)'(hi_s5) + (VW+1)'(lo_s5);
			for (int l = 0; l < 3; l++) begin
				dbl_s6[l] <= (VW+1)'(ph_s5[l]) <<< 1;
				num_s7[l] <= NW'(dbl_s6[l]) - NW'(sum_s6) + sup_term;
			end

			// out-of-range duties are pinned to an end of the period
			for (int l = 0; l < 3; l++) begin
				side_s8.pinned[l] <= (num_s7[l] < 0) || (num_s7[l] >= den);
				side_s8.pin_val[l] <= (num_s7[l] < 0) ? '0 : cfg.period;
				numlo_s8[l] <= num_s7[l][46:0];
			end
			side_s8.angle <= ang_s[7];
			side_s8.sat <= sat_s[7] | (|{num_s7[0] < 0, num_s7[0] > den,
				num_s7[1] < 0, num_s7[1] > den, num_s7[2] < 0, num_s7[2] > den});

			for (int l = 0; l < 3; l++) begin
				plo_s9[l] <= cfg.period * numlo_s8[l][23:0];
				phi_s9[l] <= cfg.period * numlo_s8[l][46:24];
			end
			side_s9 <= side_s8;

			side_s10 <= side_s9;
		end
	end

	logic [62:0] prod [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			prod[l] = {phi_s9[l], 24'd0} + 63'(plo_s9[l]);
		end
	end

	logic [2:0][XW-1:0] x_s10;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				x_s10[l] <= prod[l][62:32];
			end
		end
	end

	assign x_out = x_s10;
	assign side_out = side_s10;

endmodule

// ----- rtl/fvsd_div.sv -----
module fvsd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic [2:0][fvsd_pkg::XW-1:0]   x_in,
	input  logic [14:0]                    supply,
	input  fvsd_pkg::side_t                side_in,
	output logic                           v_out,
	output logic [2:0][fvsd_pkg::QW-1:0]   quo_out,
	output fvsd_pkg::side_t                side_out
);
	import fvsd_pkg::*;

	localparam int STAGES = QW;

	logic [14:0] sup_eff;
	assign sup_eff = (supply == 15'd0) ? 15'd1 : supply;

	logic               v_s    [STAGES+1];
	logic [2:0][XW-1:0] rem_s  [STAGES+1];
	logic [2:0][QW-1:0] quo_s  [STAGES+1];
	side_t              side_s [STAGES+1];

	assign v_s[0] = v_in;
	assign rem_s[0] = x_in;
	assign quo_s[0] = '0;
	assign side_s[0] = side_in;

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam int B = STAGES - 1 - k;
		logic [XW-1:0]      dsh;
		logic [2:0][XW-1:0] rem_n;
		logic [2:0][QW-1:0] quo_n;

		always_comb begin
			dsh = XW'(sup_eff) << B;
			rem_n = rem_s[k];
			quo_n = quo_s[k];
			for (int l = 0; l < 3; l++) begin
				if (rem_s[k][l] >= dsh) begin
					rem_n[l] = rem_s[k][l] - dsh;
					quo_n[l][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_n;
				quo_s[k+1] <= quo_n;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign v_out = v_s[STAGES];
	assign quo_out = quo_s[STAGES];
	assign side_out = side_s[STAGES];

endmodule

// ----- bench/tb_foc_voltage_to_svpwm_duty.sv -----
`timescale 1ns / 100ps

module tb_foc_voltage_to_svpwm_duty;
	import fvsd_pkg::*;

	// register index past the end of the map, writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX = 3'd7;
	// pipeline depth of the block, with margin for the drain
	localparam int PIPE_DEPTH  = 29;
	localparam int DRAIN_WAIT  = PIPE_DEPTH + 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_ITEMS  = 2000;

	// one expected duty set
	typedef struct {
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
		logic [15:0] angle;
		logic        sat;
	} duty_set_t;

	// predicts svpwm duties for each accepted request and checks the results
	class duty_checker;
		duty_set_t   pending_duties[$];
		int          fails;
		logic [6:0]  ppairs;
		logic        reverse;
		logic [15:0] offset;
		logic [14:0] vlimit;
		logic [14:0] supply;
		logic [15:0] period;

		function new();
			fails      = 0;
			ppairs     = RST_PPAIRS;
			reverse    = 1'b0;
			offset     = 16'd0;
			vlimit     = 15'd0;
			supply     = RST_SUPPLY;
			period     = RST_PERIOD;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_PPAIRS:     ppairs = data[6:0];
				REG_REVERSE:    reverse = data[0];
				REG_OFFSET:     offset = data;
				REG_VLIMIT:     vlimit = data[14:0];
				REG_SUPPLY:     supply = data[14:0];
				REG_PERIOD:     period = data;
				default: ;
			endcase
		endfunction

		// q1.15 sine of one of 256 steps per turn, q30 series on the first quadrant
		function longint sine_step(int unsigned step);
			bit [63:0] f, r, x, x2, term, acc, q;
			bit [1:0]  quad;
			f = 64'(step % 256) << 24;
			quad = f[31:30];
			r = f & 64'h3FFF_FFFF;
			if (quad[0]) begin
				r = 64'h4000_0000 - r;
			end
			x = (r * 64'd1686629713) >> 30;
			x2 = (x * x) >> 30;
			term = x;
			acc = x;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = (acc >= term) ? acc - term : 64'd0;
				end else begin
					acc = acc + term;
				end
			end
			q = (acc * 64'd32768 + 64'h2000_0000) >> 30;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			return quad[1] ? -longint'(q) : longint'(q);
		endfunction

		// {clamped, count} for twice the phase voltage in q41
		function bit [16:0] duty_of(longint v2, longint sup);
			longint     num, den;
			bit [63:0]  prod;
			den = sup <<< 32;
			num = v2 + (sup <<< 31);
			if (num < 0) begin
				return {1'b1, 16'd0};
			end
			if (num > den) begin
				return {1'b1, period};
			end
			if (num == den) begin
				return {1'b0, period};
			end
			prod = 64'(num) * 64'(period);
			return {1'b0, 16'(prod / 64'(den))};
		endfunction

		function longint clamp_v(longint v, longint lim, inout bit sat);
			if (v > lim) begin
				sat = 1'b1;
				return lim;
			end
			if (v < -lim) begin
				sat = 1'b1;
				return -lim;
			end
			return v;
		endfunction

		function void note_request(logic [11:0] mech, logic signed [15:0] vq_in,
				logic signed [15:0] vd_in);
			duty_set_t  d;
			bit         sat;
			bit [15:0]  m, e;
			bit [31:0]  prod;
			bit [16:0]  da, db, dc;
			longint     lim, vq, vd, s, c, alpha, beta, va, vb, vc, hi, lo, mid, sup;
			sat = 1'b0;
			m = {mech, 4'b0000};
			if (reverse) begin
				m = 16'(-m);
			end
			prod = 32'(m) * 32'(ppairs);
			e = 16'(prod - 32'(offset));
			lim = longint'(vlimit);
			vq = clamp_v(longint'(vq_in), lim, sat);
			vd = clamp_v(longint'(vd_in), lim, sat);
			s = sine_step(e >> 8);
			c = sine_step(16'(e + 16'd16384) >> 8);
			alpha = vd * c - vq * s;
			beta  = vd * s + vq * c;
			va = alpha * 65536;
			vb = -alpha * 32768 + beta * 56756;
			vc = -alpha * 32768 - beta * 56756;
			hi = va;
			lo = va;
			if (vb > hi) hi = vb;
			if (vc > hi) hi = vc;
			if (vb < lo) lo = vb;
			if (vc < lo) lo = vc;
			mid = hi + lo;
			// zero supply behaves as the smallest nonzero supply
			sup = (supply == 0) ? 1 : longint'(supply);
			da = duty_of(2 * va - mid, sup);
			db = duty_of(2 * vb - mid, sup);
			dc = duty_of(2 * vc - mid, sup);
			d.duty_a = da[15:0];
			d.duty_b = db[15:0];
			d.duty_c = dc[15:0];
			d.angle  = e;
			d.sat    = sat | da[16] | db[16] | dc[16];
			pending_duties.push_back(d);
		endfunction

		function void check_result(logic [15:0] a, logic [15:0] b, logic [15:0] c,
				logic [15:0] ang, logic sat);
			duty_set_t d;
			if (pending_duties.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
				return;
			end
			d = pending_duties.pop_front();
			if (a !== d.duty_a) begin
				$error("duty_a expected %0d got %0d", d.duty_a, a);
				fails++;
			end
			if (b !== d.duty_b) begin
				$error("duty_b expected %0d got %0d", d.duty_b, b);
				fails++;
			end
			if (c !== d.duty_c) begin
				$error("duty_c expected %0d got %0d", d.duty_c, c);
				fails++;
			end
			if (ang !== d.angle) begin
				$error("electrical_angle expected %0d got %0d", d.angle, ang);
				fails++;
			end
			if (sat !== d.sat) begin
				$error("saturated expected %0d got %0d", d.sat, sat);
				fails++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [11:0]           mech_angle;
	logic signed [15:0]    vq_cmd;
	logic signed [15:0]    vd_cmd;
	logic                  out_valid;
	logic                  out_ready;
	logic [15:0]           duty_a;
	logic [15:0]           duty_b;
	logic [15:0]           duty_c;
	logic [15:0]           electrical_angle;
	logic                  saturated;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	duty_checker checker_h = new();
	int          accepted;
	int          cycles;
	int          stall_pct;

	foc_voltage_to_svpwm_duty dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mech_angle       (mech_angle),
		.vq_cmd           (vq_cmd),
		.vd_cmd           (vd_cmd),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.duty_a           (duty_a),
		.duty_b           (duty_b),
		.duty_c           (duty_c),
		.electrical_angle (electrical_angle),
		.saturated        (saturated),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// both handshakes are observed with pre-edge values
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			checker_h.note_request(mech_angle, vq_cmd, vd_cmd);
			accepted <= accepted + 1;
		end
		if (arst_n && out_valid && out_ready) begin
			checker_h.check_result(duty_a, duty_b, duty_c, electrical_angle, saturated);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("foc_voltage_to_svpwm_duty test failed");
			$finish;
		end
	end

	// receiver backpressure, its own random pattern per phase
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_pct == 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// drive one request; enters and returns on a falling edge, valid left high
	task automatic send_request(logic [11:0] mech, logic signed [15:0] vq,
			logic signed [15:0] vd);
		int target;
		target = accepted + 1;
		in_valid   <= 1'b1;
		mech_angle <= mech;
		vq_cmd     <= vq;
		vd_cmd     <= vd;
		do begin
			@(negedge clk);
		end while (accepted != target);
	endtask

	task automatic idle_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// wait for every outstanding result, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (checker_h.pending_duties.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		checker_h.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(int pp, int rev, int ofs, int lim, int sup, int per);
		write_reg(REG_PPAIRS, CFG_W'(pp));
		write_reg(REG_REVERSE, CFG_W'(rev));
		write_reg(REG_OFFSET, CFG_W'(ofs));
		write_reg(REG_VLIMIT, CFG_W'(lim));
		write_reg(REG_SUPPLY, CFG_W'(sup));
		write_reg(REG_PERIOD, CFG_W'(per));
	endtask

	// voltage mostly near the clamp level, sometimes anywhere in range
	function automatic logic signed [15:0] rand_volt();
		int lim, span;
		lim = int'(checker_h.vlimit);
		if ($urandom_range(9) < 3) begin
			return 16'($urandom);
		end
		span = lim + lim / 8 + 2;
		if (span > 32767) span = 32767;
		return 16'(int'($urandom_range(2 * span)) - span);
	endfunction

	// bursts of random length with random gaps, some long bursts with no gaps
	task automatic random_traffic(int n);
		int burst, gap;
		while (n > 0) begin
			burst = ($urandom_range(9) == 0) ? 60 : $urandom_range(1, 16);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
			while (burst > 0 && n > 0) begin
				send_request(12'($urandom), rand_volt(), rand_volt());
				burst--;
				n--;
			end
			if (gap > 0) idle_sender(gap);
		end
	endtask

	initial begin
		int lim;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mech_angle = '0;
		vq_cmd     = '0;
		vd_cmd     = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		out_ready  = 1'b0;
		accepted   = 0;
		cycles     = 0;
		stall_pct  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: zero limit forces both voltages to zero
		send_request(12'd0, 16'sd0, 16'sd0);
		send_request(12'd4095, 16'sd32767, -16'sd32768);
		send_request(12'd1234, -16'sd100, 16'sd100);
		drain();

		// full limit, directed corners of every field
		write_all(7, 0, 0, 32767, 12288, 1000);
		send_request(12'd0, 16'sd32767, 16'sd0);
		send_request(12'd4095, -16'sd32768, 16'sd32767);
		send_request(12'd2048, 16'sd0, -16'sd32768);
		send_request(12'd1024, 16'sd1000, 16'sd1000);
		send_request(12'd3071, -16'sd12288, 16'sd0);
		send_request(12'd512, 16'sd0, 16'sd0);
		send_request(12'd2730, 16'sd6144, -16'sd6144);
		drain();

		// clamp edge: exactly at the limit and one past it, reversed direction
		write_all(1, 1, 65535, 5000, 4096, 65535);
		send_request(12'd100, 16'sd5000, -16'sd5000);
		send_request(12'd100, 16'sd5001, -16'sd5001);
		send_request(12'd3000, -16'sd5000, 16'sd5000);
		send_request(12'd3000, -16'sd5001, 16'sd5001);
		send_request(12'd4095, 16'sd2048, 16'sd0);
		drain();

		// zero pole pairs, zero supply, zero period, unmapped indexes ignored
		write_all(0, 0, 12345, 32767, 0, 0);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		write_reg(REG_LAST_IDX, 16'h0000);
		send_request(12'd777, 16'sd1, 16'sd0);
		send_request(12'd0, 16'sd0, 16'sd0);
		send_request(12'd4095, -16'sd1, 16'sd1);
		drain();

		// several settings, extremes first, then random
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: write_all(127, 1, 0, 32767, 32767, 65535);
				1: write_all(64, 0, 65535, 0, 1, 1);
				2: write_all(1, 0, 32768, 16384, 32767, 1000);
				3: write_all(7, 1, 0, 32767, 1, 65535);
				default: begin
					lim = $urandom_range(0, 32767);
					write_all($urandom_range(0, 127), $urandom_range(0, 1),
						$urandom_range(0, 65535), lim, $urandom_range(0, 32767),
						($urandom_range(4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(100, 4000));
				end
			endcase
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 75;
			endcase
			random_traffic(RAND_ITEMS / 10);
			drain();
		end

		stall_pct = 0;
		drain();
		if (checker_h.fails == 0) begin
			$display("foc_voltage_to_svpwm_duty test passed");
		end else begin
			$display("foc_voltage_to_svpwm_duty test failed");
		end
		$finish;
	end

endmodule
